// ----- design/sbe_pkg.sv -----
// ============================================================================
// Stack bytecode executor package
// Shared types and fixed constants for the stack machine executor: input
// item layout, opcode and fault codes, and program counter selection.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

    // Width of one machine word on the value stack.
    localparam int WORD_W    = 16;
    // Width of the packed input tdata (opcode, operand, argument, padded).
    localparam int IN_DATA_W = 40;
    // Width of the biased jump offset and of its quotient by the program depth.
    localparam int OFS_W     = 17;

    typedef logic signed [WORD_W-1:0] t_word;

    // Kind of an input item.
    typedef enum logic [1:0] {
        OP_EXEC  = 2'd0,
        OP_ARG   = 2'd1,
        OP_START = 2'd2
    } t_op;

    // Instruction opcodes in dispatch order.
    typedef enum logic [3:0] {
        OPC_EXIT  = 4'd0,
        OPC_ADD   = 4'd1,
        OPC_PUSH  = 4'd2,
        OPC_POP   = 4'd3,
        OPC_PRINT = 4'd4,
        OPC_LT    = 4'd5,
        OPC_LDA   = 4'd6,
        OPC_STA   = 4'd7,
        OPC_JZ    = 4'd8,
        OPC_JMP   = 4'd9,
        OPC_LDB   = 4'd10,
        OPC_STB   = 4'd11,
        OPC_CALL  = 4'd12,
        OPC_RET   = 4'd13
    } t_opcode;

    // Fault raised by one item.
    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_OVER  = 2'd1,
        FLT_UNDER = 2'd2,
        FLT_INDEX = 2'd3
    } t_fault;

    // Source of the next program counter.
    typedef enum logic [2:0] {
        PC_HOLD,
        PC_INC,
        PC_JUMP,
        PC_RET,
        PC_ZERO
    } t_pc_sel;

    // One accepted input item.
    typedef struct packed {
        logic [1:0] op;
        t_word      arg;
        t_word      operand;
        logic [3:0] opcode;
    } t_item;

    // Result fields carried in tdata above the program counter, lowest last.
    typedef struct packed {
        t_fault fault;
        t_word  bottom;
        t_word  top;
        t_word  print_value;
        logic   halted;
    } t_status;

endpackage

`default_nettype wire

// ----- design/stack_bytecode_executor_unit.sv -----
// ============================================================================
// Stack bytecode executor unit
// Items pass the item register, then the result register. Throughput: one
// item per cycle while the output is not stalled, set by the execute step
// over the state registers and the registered value and return stack reads.
// Reset (synchronous, active low): stacks empty, counter zero, halted.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stack_bytecode_executor_unit import sbe_pkg::*; #(
    parameter int STACK_DEPTH   = 256,
    parameter int RETURN_DEPTH  = 64,
    parameter int PROGRAM_DEPTH = 1024,
    localparam int PC_W         = $clog2(PROGRAM_DEPTH),
    localparam int OD_W         = ((PC_W + $bits(t_status) + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input items.
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata: opcode[3:0], operand[19:4], arg_value[35:20], zero padding
    input  wire logic [IN_DATA_W-1:0] i_s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]           i_s_axis_tuser,
    // Result items.
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // tdata: next_pc, halted, print_value, top_value, bottom_value,
    // fault_code, zero padding
    output logic [OD_W-1:0]           o_m_axis_tdata,
    // tuser: print_valid[0]
    output logic [0:0]                o_m_axis_tuser
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int RC_W  = $clog2(RETURN_DEPTH + 1);
    localparam int RA_W  = $clog2(RETURN_DEPTH);
    localparam int IDX_W = 18;
    localparam int R_W   = OFS_W + 2;
    localparam int S_SH  = OFS_W + PC_W;
    localparam longint unsigned R_VAL =
        ((64'd1 << S_SH) + longint'(PROGRAM_DEPTH) - 64'd1) / longint'(PROGRAM_DEPTH);
    localparam int M_VAL =
        PROGRAM_DEPTH * ((32768 + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH);

    // Handshake.
    logic accept;
    logic fire;

    // Item register.
    logic                    r_vld;
    t_item                   r_item;
    logic signed [IDX_W-1:0] r_idx;
    logic [OFS_W-1:0]        r_xu;
    logic [OFS_W-1:0]        r_q;
    logic                    r_sec0;
    logic                    r_ld0;

    // Machine state.
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_base, n_base;
    logic [RC_W-1:0]  r_rcount, n_rcount;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic             r_halt, n_halt;
    t_word            r_top, n_top;
    t_word            r_bottom, n_bot;

    // Result register.
    logic            r_out_vld;
    logic [PC_W-1:0] r_out_pc;
    logic            r_out_pvalid;
    t_status         r_stat;

    // Input side decode.
    t_item                   in_item;
    logic signed [IDX_W-1:0] idx_in;
    logic [OFS_W:0]          xu_sum;
    logic [OFS_W-1:0]        xu_in;
    logic [OFS_W+R_W-1:0]    q_prod;
    logic [SA_W-1:0]         sec_ra;
    logic [SA_W-1:0]         ld_ra;
    logic [RA_W-1:0]         ret_ra;

    // Execute step.
    t_word            sec_rd, ld_rd, sec_v, ld_v, alu;
    logic [PC_W-1:0]  ret_rd, pc_inc;
    t_pc_sel          pc_sel;
    logic             s_we, rs_we;
    logic [SA_W-1:0]  s_wa;
    t_word            s_wd;
    t_fault           fault;
    logic             pvalid;
    t_word            pval;
    logic             idx_ok, full, rfull, ret_ok, st_keep;
    logic [CNT_W-1:0] setup_wa;

    assign fire            = r_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_vld || fire;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Unpack the incoming item.
    assign in_item = '{op:      i_s_axis_tuser,
                       arg:     i_s_axis_tdata[35:20],
                       operand: i_s_axis_tdata[19:4],
                       opcode:  i_s_axis_tdata[3:0]};

    // Stack index for loads and stores, using the base after the item ahead.
    assign idx_in = {{(IDX_W - WORD_W){in_item.operand[WORD_W-1]}}, in_item.operand}
                  + (((in_item.opcode == OPC_LDB) || (in_item.opcode == OPC_STB))
                     ? IDX_W'(n_base) : IDX_W'(0));

    // Biased jump offset and its quotient by the program depth.
    assign xu_sum = {{(OFS_W + 1 - WORD_W){in_item.operand[WORD_W-1]}}, in_item.operand}
                  + (OFS_W + 1)'(M_VAL);
    assign xu_in  = xu_sum[OFS_W-1:0];
    assign q_prod = (OFS_W + R_W)'(xu_in) * (OFS_W + R_W)'(R_VAL);

    // Read addresses follow the state as the item ahead leaves it.
    assign sec_ra = SA_W'(n_count - CNT_W'(2));
    assign ld_ra  = SA_W'(idx_in);
    assign ret_ra = RA_W'(n_rcount - RC_W'(1));

    // Item register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (fire) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= in_item;
            r_idx  <= idx_in;
            r_xu   <= xu_in;
            r_q    <= OFS_W'(q_prod >> S_SH);
            r_sec0 <= (sec_ra == '0);
            r_ld0  <= (ld_ra == '0);
        end
    end

    // Value stack, kept twice for two reads; entry zero lives in r_bottom.
    sbe_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WORD_W)) u_vs_sec (
        .i_clk   (i_clk),
        .i_we    (s_we && (s_wa != '0)),
        .i_waddr (s_wa),
        .i_wdata (s_wd),
        .i_re    (accept),
        .i_raddr (sec_ra),
        .o_rdata (sec_rd)
    );

    sbe_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WORD_W)) u_vs_ld (
        .i_clk   (i_clk),
        .i_we    (s_we && (s_wa != '0)),
        .i_waddr (s_wa),
        .i_wdata (s_wd),
        .i_re    (accept),
        .i_raddr (ld_ra),
        .o_rdata (ld_rd)
    );

    // Return address stack.
    sbe_ram #(.DEPTH(RETURN_DEPTH), .WIDTH(PC_W)) u_rs (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (RA_W'(r_rcount)),
        .i_wdata (pc_inc),
        .i_re    (accept),
        .i_raddr (ret_ra),
        .o_rdata (ret_rd)
    );

    sbe_pc_next #(.PROGRAM_DEPTH(PROGRAM_DEPTH)) u_pc (
        .i_sel     (pc_sel),
        .i_pc      (r_pc),
        .i_xu      (r_xu),
        .i_q       (r_q),
        .i_ret     (ret_rd),
        .o_next_pc (n_pc),
        .o_pc_inc  (pc_inc)
    );

    // Operands and checks for the item in the register.
    assign sec_v    = r_sec0 ? r_bottom : sec_rd;
    assign ld_v     = r_ld0 ? r_bottom : ld_rd;
    assign alu      = (r_item.opcode == OPC_ADD) ? t_word'(sec_v + r_top)
                    : ((sec_v < r_top) ? t_word'(1) : t_word'(0));
    assign idx_ok   = !r_idx[IDX_W-1] && (r_idx[IDX_W-2:0] < (IDX_W - 1)'(r_count));
    assign full     = (r_count == CNT_W'(STACK_DEPTH));
    assign rfull    = (r_rcount == RC_W'(RETURN_DEPTH));
    assign ret_ok   = !r_top[WORD_W-1]
                   && ({1'b0, r_top} <= (WORD_W + 1)'(STACK_DEPTH));
    assign st_keep  = (r_count >= CNT_W'(2))
                   && (r_idx[IDX_W-2:0] == (IDX_W - 1)'(r_count - CNT_W'(2)));
    assign setup_wa = (r_count == '0) ? CNT_W'(1) : r_count;

    // Execute one item.
    always_comb begin
        n_count  = r_count;
        n_base   = r_base;
        n_rcount = r_rcount;
        n_halt   = r_halt;
        n_top    = r_top;
        n_bot    = r_bottom;
        pc_sel   = PC_HOLD;
        s_we     = 1'b0;
        s_wa     = '0;
        s_wd     = '0;
        rs_we    = 1'b0;
        fault    = FLT_NONE;
        pvalid   = 1'b0;
        pval     = '0;
        if (fire) begin
            case (r_item.op)
                OP_EXEC: begin
                    if (!r_halt) begin
                        case (r_item.opcode)
                            OPC_EXIT: begin
                                n_halt = 1'b1;
                            end
                            OPC_ADD, OPC_LT: begin
                                if (r_count < CNT_W'(2)) begin
                                    fault = FLT_UNDER;
                                end else begin
                                    n_count = r_count - CNT_W'(1);
                                    s_we    = 1'b1;
                                    s_wa    = SA_W'(r_count - CNT_W'(2));
                                    s_wd    = alu;
                                    n_top   = alu;
                                    pc_sel  = PC_INC;
                                end
                            end
                            OPC_PUSH: begin
                                if (full) begin
                                    fault = FLT_OVER;
                                end else begin
                                    s_we    = 1'b1;
                                    s_wa    = SA_W'(r_count);
                                    s_wd    = r_item.operand;
                                    n_top   = r_item.operand;
                                    n_count = r_count + CNT_W'(1);
                                    pc_sel  = PC_INC;
                                end
                            end
                            OPC_POP, OPC_PRINT: begin
                                if (r_count == '0) begin
                                    fault = FLT_UNDER;
                                end else begin
                                    n_count = r_count - CNT_W'(1);
                                    n_top   = sec_v;
                                    pc_sel  = PC_INC;
                                    if (r_item.opcode == OPC_PRINT) begin
                                        pvalid = 1'b1;
                                        pval   = r_top;
                                    end
                                end
                            end
                            OPC_LDA, OPC_LDB: begin
                                if (!idx_ok) begin
                                    fault = FLT_INDEX;
                                end else if (full) begin
                                    fault = FLT_OVER;
                                end else begin
                                    s_we    = 1'b1;
                                    s_wa    = SA_W'(r_count);
                                    s_wd    = ld_v;
                                    n_top   = ld_v;
                                    n_count = r_count + CNT_W'(1);
                                    pc_sel  = PC_INC;
                                end
                            end
                            OPC_STA, OPC_STB: begin
                                if (r_count == '0) begin
                                    fault = FLT_UNDER;
                                end else if (!idx_ok) begin
                                    fault = FLT_INDEX;
                                end else begin
                                    s_we    = 1'b1;
                                    s_wa    = SA_W'(r_idx);
                                    s_wd    = r_top;
                                    n_count = r_count - CNT_W'(1);
                                    n_top   = st_keep ? r_top : sec_v;
                                    pc_sel  = PC_INC;
                                end
                            end
                            OPC_JZ: begin
                                if (r_count == '0) begin
                                    fault = FLT_UNDER;
                                end else begin
                                    n_count = r_count - CNT_W'(1);
                                    n_top   = sec_v;
                                    pc_sel  = (r_top == '0) ? PC_JUMP : PC_INC;
                                end
                            end
                            OPC_JMP: begin
                                pc_sel = PC_JUMP;
                            end
                            OPC_CALL: begin
                                if (full || rfull) begin
                                    fault = FLT_OVER;
                                end else begin
                                    s_we     = 1'b1;
                                    s_wa     = SA_W'(r_count);
                                    s_wd     = t_word'(WORD_W'(r_base));
                                    n_top    = t_word'(WORD_W'(r_base));
                                    n_count  = r_count + CNT_W'(1);
                                    n_base   = r_count + CNT_W'(1);
                                    rs_we    = 1'b1;
                                    n_rcount = r_rcount + RC_W'(1);
                                    pc_sel   = PC_JUMP;
                                end
                            end
                            OPC_RET: begin
                                if ((r_rcount == '0) || (r_count == '0)) begin
                                    fault = FLT_UNDER;
                                end else if (!ret_ok) begin
                                    fault = FLT_INDEX;
                                end else begin
                                    n_rcount = r_rcount - RC_W'(1);
                                    n_count  = r_count - CNT_W'(1);
                                    n_base   = CNT_W'(r_top);
                                    n_top    = sec_v;
                                    // Leaving the bottom frame ends the run.
                                    if (r_rcount == RC_W'(1)) begin
                                        n_halt = 1'b1;
                                    end else begin
                                        pc_sel = PC_RET;
                                    end
                                end
                            end
                            default: begin
                                n_halt = 1'b1;
                            end
                        endcase
                        if (fault != FLT_NONE) begin
                            n_halt = 1'b1;
                        end
                    end
                end
                OP_ARG, OP_START: begin
                    if (r_halt) begin
                        if (full) begin
                            fault = FLT_OVER;
                        end else begin
                            // An empty stack first gets the result slot.
                            if (r_count == '0) begin
                                n_bot = '0;
                            end
                            s_we    = 1'b1;
                            s_wa    = SA_W'(setup_wa);
                            s_wd    = (r_item.op == OP_ARG) ? r_item.arg : t_word'(0);
                            n_top   = s_wd;
                            n_count = setup_wa + CNT_W'(1);
                            if (r_item.op == OP_START) begin
                                n_rcount = RC_W'(1);
                                n_base   = setup_wa + CNT_W'(1);
                                pc_sel   = PC_ZERO;
                                n_halt   = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            // Entry zero is held in a register rather than in the RAM.
            if (s_we && (s_wa == '0)) begin
                n_bot = s_wd;
            end
        end
    end

    // Machine state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_base   <= '0;
            r_rcount <= '0;
            r_pc     <= '0;
            r_halt   <= 1'b1;
        end else begin
            r_count  <= n_count;
            r_base   <= n_base;
            r_rcount <= n_rcount;
            r_pc     <= n_pc;
            r_halt   <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_bottom <= n_bot;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pc     <= n_pc;
            r_out_pvalid <= pvalid;
            r_stat       <= '{fault:       fault,
                              bottom:      (n_count != '0) ? n_bot : t_word'(0),
                              top:         (n_count != '0) ? n_top : t_word'(0),
                              print_value: pval,
                              halted:      n_halt};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OD_W'({r_stat, r_out_pc});
    assign o_m_axis_tuser  = r_out_pvalid;

endmodule

`default_nettype wire

// ----- design/sbe_ram.sv -----
// ============================================================================
// Stack bytecode executor RAM
// Single write port, single registered read port memory. A read at the
// address written in the same cycle returns the new data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sbe_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic [WIDTH-1:0] r_wdata;
    logic             r_byp;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read with write-through for a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
            r_byp   <= i_we && (i_waddr == i_raddr);
            r_wdata <= i_wdata;
        end
    end

    assign o_rdata = r_byp ? r_wdata : r_rdata;

endmodule

`default_nettype wire

// ----- design/sbe_pc_next.sv -----
// ============================================================================
// Stack bytecode executor program counter unit
// Picks the next program counter: hold, increment, relative jump, return
// address or zero, all wrapping modulo the program depth. The jump offset
// arrives pre-reduced as a biased value and its quotient by the depth.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sbe_pc_next import sbe_pkg::*; #(
    parameter int PROGRAM_DEPTH = 1024,
    localparam int PC_W         = $clog2(PROGRAM_DEPTH)
) (
    input  wire t_pc_sel         i_sel,
    input  wire logic [PC_W-1:0] i_pc,
    input  wire logic [OFS_W-1:0] i_xu,
    input  wire logic [OFS_W-1:0] i_q,
    input  wire logic [PC_W-1:0] i_ret,
    output logic      [PC_W-1:0] o_next_pc,
    output logic      [PC_W-1:0] o_pc_inc
);

    localparam logic [PC_W:0] DEPTH_C = (PC_W + 1)'(PROGRAM_DEPTH);

    logic [2*OFS_W-1:0] qp;
    logic [PC_W-1:0]    off;
    logic [PC_W:0]      jsum;
    logic [PC_W:0]      isum;
    logic [PC_W-1:0]    jpc;

    // Offset modulo depth: biased offset minus quotient times depth.
    assign qp   = (2 * OFS_W)'(i_q) * (2 * OFS_W)'(PROGRAM_DEPTH);
    assign off  = PC_W'((2 * OFS_W)'(i_xu) - qp);

    // Jump target and increment, each wrapped with one compare.
    assign jsum = {1'b0, i_pc} + {1'b0, off};
    assign jpc  = (jsum >= DEPTH_C) ? PC_W'(jsum - DEPTH_C) : PC_W'(jsum);
    assign isum = {1'b0, i_pc} + (PC_W + 1)'(1);
    assign o_pc_inc = (isum == DEPTH_C) ? '0 : PC_W'(isum);

    always_comb begin
        case (i_sel)
            PC_HOLD: o_next_pc = i_pc;
            PC_INC:  o_next_pc = o_pc_inc;
            PC_JUMP: o_next_pc = jpc;
            PC_RET:  o_next_pc = i_ret;
            PC_ZERO: o_next_pc = '0;
            default: o_next_pc = i_pc;
        endcase
    end

endmodule

`default_nettype wire
